/* sv/il2i_pkg.sv */
// Shared types and constants for the integer literal converter.
package il2i_pkg;

  localparam int unsigned MagW  = 64;
  localparam int unsigned ProdW = MagW + 4;  // magnitude times sixteen plus a digit

  localparam logic [7:0] ChUnderscore = 8'h5F;
  localparam logic [7:0] ChZero       = 8'h30;
  localparam logic [7:0] ChNine       = 8'h39;
  localparam logic [7:0] ChLowA       = 8'h61;
  localparam logic [7:0] ChLowZ       = 8'h7A;
  localparam logic [7:0] ChUpA        = 8'h41;
  localparam logic [7:0] ChUpZ        = 8'h5A;
  localparam logic [7:0] ChLowX       = 8'h78;
  localparam logic [7:0] ChUpX        = 8'h58;
  localparam logic [7:0] ChLowB       = 8'h62;
  localparam logic [7:0] ChUpB        = 8'h42;
  localparam logic [7:0] LowLetterOff = 8'd87;  // 'a' maps to ten
  localparam logic [7:0] UpLetterOff  = 8'd55;  // 'A' maps to ten

  localparam logic [MagW-1:0] LimitPos = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [MagW-1:0] LimitNeg = 64'h8000_0000_0000_0000;

  localparam logic [1:0] PosLast = 2'd3;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_BIN = 2'd2
  } radix_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRAIL_US  = 3'd1,
    ST_BAD_CHAR  = 3'd2,
    ST_MALFORMED = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_LEAD_ZERO = 3'd5
  } status_e;

  typedef struct packed {
    logic [MagW-1:0] magnitude;
    radix_e          radix;
    logic [1:0]      pos;
    logic            sign;
    logic            zero_first;
    logic            err_bad_char;
    logic            err_bad_digit;
    logic            err_overflow;
    logic            digit_seen;
  } lit_state_t;

  localparam lit_state_t LitStateReset = '{
    magnitude:     '0,
    radix:         RADIX_DEC,
    pos:           2'd0,
    sign:          1'b0,
    zero_first:    1'b0,
    err_bad_char:  1'b0,
    err_bad_digit: 1'b0,
    err_overflow:  1'b0,
    digit_seen:    1'b0
  };

endpackage

/* sv/il2i_step.sv */
// Per-character next-state and result logic for the literal accumulator.
module il2i_step import il2i_pkg::*; (
  input  lit_state_t      state_i,
  input  logic [7:0]      ch_i,
  input  logic            negative_i,
  input  logic            last_i,
  output lit_state_t      state_o,
  output logic [MagW-1:0] value_o,
  output status_e         status_o
);

  logic             is_us;
  logic             cv_ok;
  logic [5:0]       cv;
  logic             is_prefix_ch;
  logic             is_prefix;
  logic [5:0]       base;
  logic             digit_ok;
  logic [1:0]       first_pos;
  logic             sign;
  logic [ProdW-1:0] prod;
  logic [ProdW-1:0] acc;
  logic [MagW-1:0]  limit;
  logic             ovf_now;
  lit_state_t       nxt;

  assign is_us = (ch_i == ChUnderscore);
  assign sign  = (state_i.pos == 2'd0) ? negative_i : state_i.sign;

  // Map digits and letters onto 0..35
  always_comb begin
    cv_ok = 1'b1;
    cv    = '0;
    if (ch_i >= ChZero && ch_i <= ChNine) begin
      cv = 6'(ch_i - ChZero);
    end else if (ch_i >= ChLowA && ch_i <= ChLowZ) begin
      cv = 6'(ch_i - LowLetterOff);
    end else if (ch_i >= ChUpA && ch_i <= ChUpZ) begin
      cv = 6'(ch_i - UpLetterOff);
    end else begin
      cv_ok = 1'b0;
    end
  end

  assign is_prefix_ch = (ch_i == ChLowX) || (ch_i == ChUpX) ||
                        (ch_i == ChLowB) || (ch_i == ChUpB);
  assign is_prefix    = cv_ok && is_prefix_ch && (state_i.pos == 2'd1) &&
                        (state_i.radix == RADIX_DEC) && state_i.zero_first;

  // Scale by the base with shifts and one add
  always_comb begin
    unique case (state_i.radix)
      RADIX_HEX: begin
        base      = 6'd16;
        first_pos = 2'd2;
        prod      = {state_i.magnitude, 4'b0};
      end
      RADIX_BIN: begin
        base      = 6'd2;
        first_pos = 2'd2;
        prod      = {3'b0, state_i.magnitude, 1'b0};
      end
      default: begin
        base      = 6'd10;
        first_pos = 2'd0;
        prod      = {1'b0, state_i.magnitude, 3'b0} + {3'b0, state_i.magnitude, 1'b0};
      end
    endcase
  end

  assign digit_ok = (cv < base);
  assign acc      = prod + {{(ProdW-6){1'b0}}, cv};
  assign limit    = sign ? LimitNeg : LimitPos;
  assign ovf_now  = (acc > {4'b0, limit});

  always_comb begin
    nxt      = state_i;
    nxt.sign = sign;
    if (!is_us) begin
      if (!cv_ok) begin
        nxt.err_bad_char = 1'b1;
      end else if (is_prefix) begin
        nxt.radix      = (ch_i == ChLowX || ch_i == ChUpX) ? RADIX_HEX : RADIX_BIN;
        nxt.zero_first = 1'b0;
        nxt.digit_seen = 1'b0;
        nxt.magnitude  = '0;
      end else if (!digit_ok) begin
        nxt.err_bad_digit = 1'b1;
      end else begin
        if (state_i.pos == first_pos && ch_i == ChZero) begin
          nxt.zero_first = 1'b1;
        end
        nxt.digit_seen = 1'b1;
        if (!state_i.err_overflow) begin
          if (ovf_now) begin
            nxt.err_overflow = 1'b1;
          end else begin
            nxt.magnitude = acc[MagW-1:0];
          end
        end
      end
    end
    if (state_i.pos != PosLast) begin
      nxt.pos = state_i.pos + 2'd1;
    end
  end

  always_comb begin
    value_o  = '0;
    status_o = ST_OK;
    if (is_us) begin
      status_o = ST_TRAIL_US;
    end else if (nxt.err_bad_char) begin
      status_o = ST_BAD_CHAR;
    end else if (nxt.err_bad_digit || !nxt.digit_seen) begin
      status_o = ST_MALFORMED;
    end else if (nxt.err_overflow) begin
      status_o = ST_OVERFLOW;
    end else if (nxt.zero_first && nxt.magnitude != '0) begin
      status_o = ST_LEAD_ZERO;
    end else begin
      value_o = nxt.sign ? (MagW'(0) - nxt.magnitude) : nxt.magnitude;
    end
  end

  // Return to the idle literal after the final character
  assign state_o = last_i ? LitStateReset : nxt;

endmodule

/* sv/integer_literal_to_int64.sv */
// Top level: ASCII integer literal to signed 64-bit value converter.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------------
//   in      | sink      | in_valid_i / in_stall_o   | ch_i, negative_i, last_i
//   out     | source    | out_valid_o / out_stall_i | value_o, status_o
//
// One character beat is taken every cycle while the input register can advance; a
// final character waits there until the result register is free. Its result beat
// goes from the input register through the accumulator step into the result register.
// The loop that sets the rate is the magnitude update: scale by the base,
// add the digit and compare against the int64 limit, all combinationally.
// Reset clears the pipeline valids and the literal state; payload registers
// are left alone.
// A stalled result only holds the input register when it carries a final
// character; other characters keep flowing into the accumulator.
module integer_literal_to_int64 import il2i_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             ch_i,
  input  logic                   negative_i,
  input  logic                   last_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [MagW-1:0] value_o,
  output logic [2:0]             status_o
);

  // Input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_ch_q;
  logic       s1_neg_q;
  logic       s1_last_q;

  // Literal state and result register
  lit_state_t      lit_q, lit_d;
  logic            res_valid_q, res_valid_d;
  logic [MagW-1:0] value_q, step_value;
  status_e         status_q, step_status;

  logic res_free;
  logic s1_go;
  logic in_take;

  // The result slot frees when empty or when its beat is taken this cycle
  assign res_free = !res_valid_q || !out_stall_i;
  // Advance a character unless it is final and the result slot is busy
  assign s1_go    = s1_valid_q && (!s1_last_q || res_free);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_take  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (s1_go && s1_last_q) begin
      res_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      res_valid_d = 1'b0;
    end
  end

  il2i_step u_step (
    .state_i    (lit_q),
    .ch_i       (s1_ch_q),
    .negative_i (s1_neg_q),
    .last_i     (s1_last_q),
    .state_o    (lit_d),
    .value_o    (step_value),
    .status_o   (step_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      lit_q       <= LitStateReset;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
      if (s1_go) begin
        lit_q <= lit_d;
      end
    end
  end

  // Capture the incoming beat
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_ch_q   <= ch_i;
      s1_neg_q  <= negative_i;
      s1_last_q <= last_i;
    end
  end

  // Load the result beat at the final character
  always_ff @(posedge clk_i) begin
    if (s1_go && s1_last_q) begin
      value_q  <= step_value;
      status_q <= step_status;
    end
  end

  assign out_valid_o = res_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

/* test/integer_literal_to_int64_checker.sv */
// Checker for the literal converter: predicts each result beat and compares it.
`timescale 1ns / 100ps
module integer_literal_to_int64_checker import il2i_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [7:0]             ch_i,
  input  logic                   negative_i,
  input  logic                   last_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic signed [MagW-1:0] value_i,
  input  logic [2:0]             status_i,
  output int unsigned            fail_count_o,
  output int unsigned            pending_o
);

  localparam logic [7:0]      NoDigit  = 8'hFF;
  localparam logic [MagW-1:0] BaseDec  = 64'd10;
  localparam logic [MagW-1:0] BaseHex  = 64'd16;
  localparam logic [MagW-1:0] BaseBin  = 64'd2;
  localparam int unsigned     PrintCap = 60;

  typedef struct {
    logic [MagW-1:0] value;
    status_e         status;
  } literal_result_t;

  literal_result_t expected_results[$];

  // Accumulator of the literal in flight.
  logic [MagW-1:0] acc_mag;
  radix_e          acc_radix;
  logic [1:0]      acc_pos;
  logic            acc_sign;
  logic            acc_zero_first;
  logic            acc_bad_char;
  logic            acc_bad_digit;
  logic            acc_overflow;
  logic            acc_digit_seen;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string what);
    if (fail_count_o < PrintCap) $display("mismatch at %0t: %s", $realtime, what);
    fail_count_o++;
  endtask

  task automatic restart_literal();
    acc_mag        = '0;
    acc_radix      = RADIX_DEC;
    acc_pos        = 2'd0;
    acc_sign       = 1'b0;
    acc_zero_first = 1'b0;
    acc_bad_char   = 1'b0;
    acc_bad_digit  = 1'b0;
    acc_overflow   = 1'b0;
    acc_digit_seen = 1'b0;
  endtask

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    if (c >= ChZero && c <= ChNine) return c - ChZero;
    if (c >= ChLowA && c <= ChLowZ) return c - LowLetterOff;
    if (c >= ChUpA && c <= ChUpZ) return c - UpLetterOff;
    return NoDigit;
  endfunction

  task automatic absorb_char(input logic [7:0] c, input logic neg, input logic fin);
    logic [7:0]      dv;
    logic [MagW-1:0] base;
    logic [MagW-1:0] lim;
    logic [1:0]      pos;
    logic [1:0]      first_pos;
    literal_result_t res;
    pos = acc_pos;
    if (pos == 2'd0) acc_sign = neg;
    if (fin && c == ChUnderscore) begin
      res.value  = '0;
      res.status = ST_TRAIL_US;
      expected_results.push_back(res);
      restart_literal();
    end else begin
      if (c != ChUnderscore) begin
        dv = digit_value(c);
        if (dv == NoDigit) begin
          acc_bad_char = 1'b1;
        end else if (pos == 2'd1 && acc_radix == RADIX_DEC && acc_zero_first &&
                     (c == ChLowX || c == ChUpX || c == ChLowB || c == ChUpB)) begin
          // radix prefix: restart the digits in the new base
          acc_radix      = (c == ChLowX || c == ChUpX) ? RADIX_HEX : RADIX_BIN;
          acc_zero_first = 1'b0;
          acc_digit_seen = 1'b0;
          acc_mag        = '0;
        end else begin
          base      = (acc_radix == RADIX_HEX) ? BaseHex :
                      (acc_radix == RADIX_BIN) ? BaseBin : BaseDec;
          first_pos = (acc_radix == RADIX_HEX || acc_radix == RADIX_BIN) ? 2'd2 : 2'd0;
          if ({56'd0, dv} >= base) begin
            acc_bad_digit = 1'b1;
          end else begin
            lim = acc_sign ? LimitNeg : LimitPos;
            if (pos == first_pos && c == ChZero) acc_zero_first = 1'b1;
            acc_digit_seen = 1'b1;
            if (!acc_overflow) begin
              if (acc_mag > (lim - {56'd0, dv}) / base) acc_overflow = 1'b1;
              else acc_mag = acc_mag * base + {56'd0, dv};
            end
          end
        end
      end
      if (pos != PosLast) acc_pos = pos + 2'd1;
      if (fin) begin
        res.value = '0;
        if (acc_bad_char) res.status = ST_BAD_CHAR;
        else if (acc_bad_digit || !acc_digit_seen) res.status = ST_MALFORMED;
        else if (acc_overflow) res.status = ST_OVERFLOW;
        else if (acc_zero_first && acc_mag != '0) res.status = ST_LEAD_ZERO;
        else begin
          res.status = ST_OK;
          res.value  = acc_sign ? -acc_mag : acc_mag;
        end
        expected_results.push_back(res);
        restart_literal();
      end
    end
  endtask

  task automatic check_result(input logic [MagW-1:0] v, input logic [2:0] s);
    literal_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result beat with none expected: value %0h status %0d", v, s));
    end else begin
      want = expected_results.pop_front();
      if (s !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", s, want.status));
      if (v !== want.value)
        report_mismatch($sformatf("value %0h, expected %0h", v, want.value));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_literal();
      expected_results.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result(value_i, status_i);
      if (in_valid_i && !in_stall_i) absorb_char(ch_i, negative_i, last_i);
      pending_o = expected_results.size();
    end
  end

endmodule

/* test/integer_literal_to_int64_tb.sv */
// Testbench top for the literal converter: stimulus, result stalls and verdict.
`timescale 1ns / 100ps
module integer_literal_to_int64_tb import il2i_pkg::*;;

  // Character beats in the random part, and the one long result hold-off.
  localparam int unsigned RandomChars   = 520;
  localparam int unsigned SqueezeAfter  = 150;
  localparam int unsigned SqueezeCycles = 200;
  localparam int unsigned DrainCycles   = 8;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic [7:0]             ch        = '0;
  logic                   negative  = 1'b0;
  logic                   is_last   = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [MagW-1:0] value;
  logic [2:0]             status;

  int unsigned fail_count;
  int unsigned pending;

  // Calm flags give stretches without idling on either side.
  bit          send_calm    = 1'b0;
  bit          recv_calm    = 1'b0;
  bit          squeeze_req  = 1'b0;
  bit          squeeze_done = 1'b0;
  int unsigned chars_sent   = 0;

  // Characters of the literal about to be sent.
  byte unsigned text_q[$];

  integer_literal_to_int64 u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .ch_i        (ch),
    .negative_i  (negative),
    .last_i      (is_last),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .value_o     (value),
    .status_o    (status)
  );

  integer_literal_to_int64_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .ch_i         (ch),
    .negative_i   (negative),
    .last_i       (is_last),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .value_i      (value),
    .status_i     (status),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle lengths for both sides: usually short, and about one time in ten a long one.
  function automatic int unsigned pick_idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
  endfunction

  // Offer one character beat and hold it until it is taken. Enter and leave on a
  // falling edge, so that every input changes on the edge opposite to sampling.
  task automatic send_beat(input logic [7:0] c, input logic neg, input logic fin);
    int unsigned gap;
    gap = (!send_calm && $urandom_range(0, 2) == 0) ? pick_idle_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    ch       <= c;
    negative <= neg;
    is_last  <= fin;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    chars_sent++;
  endtask

  // Send the queued literal; the sign flag only matters on the first beat, so
  // toggle it freely on the others.
  task automatic send_literal(input bit neg);
    foreach (text_q[i])
      send_beat(text_q[i], (i == 0) ? neg : 1'($urandom_range(0, 1)),
                i == text_q.size() - 1);
  endtask

  task automatic send_text(input string s, input bit neg);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_literal(neg);
  endtask

  function automatic byte unsigned random_digit(input radix_e r);
    string hex_digits = "0123456789abcdefABCDEF";
    case (r)
      RADIX_HEX: return hex_digits[$urandom_range(0, 21)];
      RADIX_BIN: return 8'(ChZero + $urandom_range(0, 1));
      default:   return 8'(ChZero + $urandom_range(0, 9));
    endcase
  endfunction

  task automatic push_prefix(input radix_e r);
    text_q.push_back(ChZero);
    if (r == RADIX_HEX) text_q.push_back($urandom_range(0, 1) ? ChLowX : ChUpX);
    else text_q.push_back($urandom_range(0, 1) ? ChLowB : ChUpB);
  endtask

  // Digits of the base, with the odd underscore in front of or between them.
  task automatic push_body(input radix_e r, input int unsigned len, input bit no_lead_zero);
    byte unsigned digit;
    if ($urandom_range(0, 11) == 0) text_q.push_back(ChUnderscore);
    for (int unsigned k = 0; k < len; k++) begin
      digit = random_digit(r);
      if (k == 0 && no_lead_zero)
        while (digit == ChZero) digit = random_digit(r);
      text_q.push_back(digit);
      if (k + 1 < len && $urandom_range(0, 7) == 0) text_q.push_back(ChUnderscore);
    end
  endtask

  // Values on and around the int64 limits, all ones or a random value, printed in the literal's base.
  task automatic push_boundary(input radix_e r);
    logic [MagW-1:0] v;
    string           s;
    case ($urandom_range(0, 3))
      0:       v = LimitPos - 64'($urandom_range(0, 2));
      1:       v = LimitNeg + 64'($urandom_range(0, 1));
      2:       v = '1;
      default: v = {$urandom, $urandom};
    endcase
    case (r)
      RADIX_HEX: s = $sformatf("%0h", v);
      RADIX_BIN: s = $sformatf("%0b", v);
      default:   s = $sformatf("%0d", v);
    endcase
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic build_wellformed();
    radix_e      r;
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    r    = (pick < 45) ? RADIX_DEC : (pick < 78) ? RADIX_HEX : RADIX_BIN;
    text_q.delete();
    if (r != RADIX_DEC) push_prefix(r);
    if ($urandom_range(0, 9) == 0) begin
      push_boundary(r);
    end else begin
      // keep most literals short; a few run up to and past 64 bits
      case (r)
        RADIX_HEX: len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 17)
                                                      : $urandom_range(1, 5);
        RADIX_BIN: len = ($urandom_range(0, 11) == 0) ? $urandom_range(62, 65)
                                                       : $urandom_range(1, 8);
        default:   len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 21)
                                                      : $urandom_range(1, 6);
      endcase
      push_body(r, len, $urandom_range(0, 7) != 0);
    end
  endtask

  // Take a well-formed literal and break it in one of several ways.
  task automatic build_broken();
    build_wellformed();
    case ($urandom_range(0, 4))
      0: text_q[$urandom_range(0, text_q.size() - 1)] = $urandom_range(0, 255);
      1: text_q.push_back(ChUnderscore);
      2: text_q.push_front(ChZero);
      3: begin
        // extra prefix in front of the literal, before any prefix it has
        text_q.push_front($urandom_range(0, 1) ? ChLowX : ChUpB);
        text_q.push_front(ChZero);
      end
      default: begin
        text_q.delete();
        push_prefix($urandom_range(0, 1) ? RADIX_HEX : RADIX_BIN);
      end
    endcase
  endtask

  task automatic build_noise();
    text_q.delete();
    repeat ($urandom_range(1, 5))
      text_q.push_back($urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(32, 126));
  endtask

  initial begin : stimulus
    int unsigned random_start;
    int unsigned kind;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero forms, prefixes alone, underscores, bad characters,
    // digits foreign to the base, repeated prefix and the int64 extremes.
    send_text("0", 1'b0);
    send_text("00", 1'b1);
    send_text("07", 1'b0);
    send_text("0x01", 1'b0);
    send_text("0x", 1'b0);
    send_text("0B", 1'b1);
    send_text("_", 1'b0);
    send_text("1_", 1'b1);
    send_text("_5", 1'b0);
    send_text("4+2", 1'b0);
    send_text("0x0x1", 1'b0);
    send_text("0b102", 1'b0);
    send_text("9z", 1'b0);
    send_text("0XfF_a", 1'b1);
    send_text("0b1_01", 1'b0);
    send_text("_0x1", 1'b0);
    send_text("0x7FFFFFFFFFFFFFFF", 1'b0);
    send_text("0x8000000000000000", 1'b1);
    send_text("0x8000000000000000", 1'b0);
    send_text("99999999999999999999", 1'b1);
    text_q = '{8'h31, 8'hFF, 8'h32};
    send_literal(1'b0);
    text_q = '{8'h00};
    send_literal(1'b1);

    // Random: mostly well-formed literals, the rest broken ones and noise.
    random_start = chars_sent;
    while (chars_sent < random_start + RandomChars) begin
      if (!squeeze_req && chars_sent >= random_start + SqueezeAfter) squeeze_req = 1'b1;
      if ($urandom_range(0, 7) == 0) send_calm = !send_calm;
      kind = $urandom_range(0, 99);
      if (kind < 70) build_wellformed();
      else if (kind < 88) build_broken();
      else build_noise();
      send_literal($urandom_range(0, 1));
    end
    in_valid <= 1'b0;

    // Drain: wait for every expected beat, then keep watching for strays.
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Result side: random stalls, calm stretches, and once a long hold-off while
  // the sender keeps going, so the block fills up and stalls its input.
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        out_stall <= 1'b1;
        repeat (SqueezeCycles) @(negedge clk);
      end
      if ($urandom_range(0, 99) == 0) recv_calm = !recv_calm;
      if (stall_left == 0 && !recv_calm && $urandom_range(0, 3) == 0)
        stall_left = pick_idle_len();
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Hard stop well beyond the slowest correct run.
  initial begin : watchdog
    #(5_000_000);
    $display("status: fail");
    $finish;
  end

endmodule
